// ===== hdl/cwc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cwc_pkg
// types and constants shared by the command word classifier and its checker
// ---------------------------------------------------------------------------
package cwc_pkg;

    typedef enum logic [3:0] {
        CLS_LS       = 4'd0,
        CLS_CD       = 4'd1,
        CLS_CAT      = 4'd2,
        CLS_PRINT    = 4'd3,
        CLS_EXEC     = 4'd4,
        CLS_SET      = 4'd5,
        CLS_ECHO     = 4'd6,
        CLS_VARIABLE = 4'd7,
        CLS_QUOTED   = 4'd8,
        CLS_FILE     = 4'd9,
        CLS_FOLDER   = 4'd10,
        CLS_ROOT     = 4'd11,
        CLS_UNKNOWN  = 4'd12,
        CLS_EQUAL    = 4'd13
    } t_token_class;

    typedef enum logic [1:0] {
        QUOTE_DEAD   = 2'd0,
        QUOTE_OPEN   = 2'd1,
        QUOTE_CLOSED = 2'd2
    } t_quote_phase;

    typedef enum logic [1:0] {
        DOT_BASE = 2'd0,
        DOT_EXT  = 2'd1,
        DOT_DEAD = 2'd2
    } t_dot_phase;

    localparam int NUM_LIT  = 9;
    localparam int LIT_ROOT = 8;

    localparam logic [7:0] LIT_TEXT [0:NUM_LIT-1][0:7] = '{
        '{8'h6c, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h63, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h63, 8'h61, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h70, 8'h72, 8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h78, 8'h65, 8'h63, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h63, 8'h68, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3d, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [7:0] LIT_LEN [0:NUM_LIT-1] = '{
        8'd2, 8'd2, 8'd3, 8'd5, 8'd4, 8'd3, 8'd4, 8'd1, 8'd1
    };

    localparam t_token_class LIT_CLASS [0:NUM_LIT-1] = '{
        CLS_LS, CLS_CD, CLS_CAT, CLS_PRINT, CLS_EXEC, CLS_SET, CLS_ECHO,
        CLS_EQUAL, CLS_ROOT
    };

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;

    localparam logic [3:0] BASE_MAX = 4'd9;
    localparam logic [3:0] BASE_OK  = 4'd8;
    localparam logic [2:0] EXT_MAX  = 3'd4;
    localparam logic [2:0] EXT_LEN  = 3'd3;
    localparam logic [7:0] LEN_MAX  = 8'd255;

endpackage

// ===== hdl/command_word_classifier_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// command_word_classifier_core
// splits a character stream into words and reports class and length per word
// ---------------------------------------------------------------------------
// channel  dir  tdata                                 tlast
// s_*      in   [7:0] char_code                       end_of_command
// m_*      out  [3:0] token_class, [11:4] word_length closes_command
//
// one character beat per cycle sustained while no word-ending beat waits on a stalled
// result; that beat passes the input register, then its word result the result register
// synchronous active-low reset empties both registers and the word state
// a stalled result holds only beats that end a word; other beats keep flowing
// ---------------------------------------------------------------------------
module command_word_classifier_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] token_class, [11:4] word_length
    output logic        m_tlast
);

    logic                   r_in_valid;
    logic [7:0]             r_in_char;
    logic                   r_in_last;

    logic                   r_inside;
    logic [7:0]             r_len;
    logic [cwc_pkg::NUM_LIT-1:0] r_alive;
    logic                   r_dollar;
    cwc_pkg::t_quote_phase  r_quote;
    logic [3:0]             r_base;
    cwc_pkg::t_dot_phase    r_dot;
    logic [2:0]             r_ext;

    logic                   r_out_valid;
    cwc_pkg::t_token_class  r_out_class;
    logic [7:0]             r_out_len;
    logic                   r_out_last;

    logic [7:0]             n_len;
    logic [cwc_pkg::NUM_LIT-1:0] n_alive;
    logic                   n_dollar;
    cwc_pkg::t_quote_phase  n_quote;
    logic [3:0]             n_base;
    cwc_pkg::t_dot_phase    n_dot;
    logic [2:0]             n_ext;

    logic                   w_space;
    logic                   w_alnum;
    logic                   w_emit;
    logic                   w_out_free;
    logic                   w_proc;
    logic                   w_clear;
    logic                   w_lit_hit;
    cwc_pkg::t_token_class  w_class;

    always_comb begin
        w_space = (r_in_char == cwc_pkg::CH_SPACE) ||
                  ((r_in_char >= cwc_pkg::CH_TAB) && (r_in_char <= cwc_pkg::CH_CR));
        w_alnum = ((r_in_char >= 8'h30) && (r_in_char <= 8'h39)) ||
                  ((r_in_char >= 8'h61) && (r_in_char <= 8'h7a)) ||
                  ((r_in_char >= 8'h41) && (r_in_char <= 8'h5a));
    end

    // word state update for a non-whitespace character
    always_comb begin
        n_len    = r_len;
        n_alive  = r_alive;
        n_dollar = r_dollar;
        n_quote  = r_quote;
        n_base   = r_base;
        n_dot    = r_dot;
        n_ext    = r_ext;
        if (!w_space) begin
            for (int i = 0; i < cwc_pkg::NUM_LIT; i++) begin
                if (!((r_len < cwc_pkg::LIT_LEN[i]) &&
                      (cwc_pkg::LIT_TEXT[i][r_len[2:0]] == r_in_char))) begin
                    n_alive[i] = 1'b0;
                end
            end

            if (r_len == 8'd0) begin
                n_dollar = (r_in_char == cwc_pkg::CH_DOLLAR);
                n_quote  = (r_in_char == cwc_pkg::CH_QUOTE) ? cwc_pkg::QUOTE_OPEN
                                                            : cwc_pkg::QUOTE_DEAD;
            end else begin
                if (!w_alnum) begin
                    n_dollar = 1'b0;
                end
                if (r_quote == cwc_pkg::QUOTE_OPEN) begin
                    if (r_in_char == cwc_pkg::CH_QUOTE) begin
                        n_quote = cwc_pkg::QUOTE_CLOSED;
                    end
                end else begin
                    n_quote = cwc_pkg::QUOTE_DEAD;
                end
            end

            case (r_dot)
                cwc_pkg::DOT_BASE: begin
                    if (w_alnum) begin
                        if (r_base < cwc_pkg::BASE_MAX) begin
                            n_base = r_base + 4'd1;
                        end
                    end else if ((r_in_char == cwc_pkg::CH_DOT) && (r_base != 4'd0) &&
                                 (r_base <= cwc_pkg::BASE_OK)) begin
                        n_dot = cwc_pkg::DOT_EXT;
                    end else begin
                        n_dot = cwc_pkg::DOT_DEAD;
                    end
                end
                cwc_pkg::DOT_EXT: begin
                    if (w_alnum) begin
                        if (r_ext < cwc_pkg::EXT_MAX) begin
                            n_ext = r_ext + 3'd1;
                        end
                    end else begin
                        n_dot = cwc_pkg::DOT_DEAD;
                    end
                end
                default: begin
                end
            endcase

            if (r_len != cwc_pkg::LEN_MAX) begin
                n_len = r_len + 8'd1;
            end
        end
    end

    // class of the word as it stands after this character
    always_comb begin
        w_class   = cwc_pkg::CLS_UNKNOWN;
        w_lit_hit = 1'b0;
        for (int i = 0; i < cwc_pkg::LIT_ROOT; i++) begin
            if (!w_lit_hit && n_alive[i] && (n_len == cwc_pkg::LIT_LEN[i])) begin
                w_class   = cwc_pkg::LIT_CLASS[i];
                w_lit_hit = 1'b1;
            end
        end
        if (!w_lit_hit) begin
            if (n_dollar && (n_len >= 8'd2)) begin
                w_class = cwc_pkg::CLS_VARIABLE;
            end else if (n_quote == cwc_pkg::QUOTE_CLOSED) begin
                w_class = cwc_pkg::CLS_QUOTED;
            end else if ((n_dot == cwc_pkg::DOT_EXT) && (n_ext == cwc_pkg::EXT_LEN)) begin
                w_class = cwc_pkg::CLS_FILE;
            end else if ((n_dot == cwc_pkg::DOT_BASE) && (n_base != 4'd0) &&
                         (n_base <= cwc_pkg::BASE_OK)) begin
                w_class = cwc_pkg::CLS_FOLDER;
            end else if (n_alive[cwc_pkg::LIT_ROOT] &&
                         (n_len == cwc_pkg::LIT_LEN[cwc_pkg::LIT_ROOT])) begin
                w_class = cwc_pkg::CLS_ROOT;
            end
        end
    end

    always_comb begin
        w_emit     = w_space ? r_inside : r_in_last;
        w_out_free = !r_out_valid || m_tready;
        w_proc     = r_in_valid && (!w_emit || w_out_free);
        w_clear    = w_emit || r_in_last;
        s_tready   = !r_in_valid || w_proc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            r_in_char <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_len    <= 8'd0;
            r_alive  <= '1;
            r_dollar <= 1'b0;
            r_quote  <= cwc_pkg::QUOTE_DEAD;
            r_base   <= 4'd0;
            r_dot    <= cwc_pkg::DOT_BASE;
            r_ext    <= 3'd0;
        end else if (w_proc) begin
            if (w_clear) begin
                r_inside <= 1'b0;
                r_len    <= 8'd0;
                r_alive  <= '1;
                r_dollar <= 1'b0;
                r_quote  <= cwc_pkg::QUOTE_DEAD;
                r_base   <= 4'd0;
                r_dot    <= cwc_pkg::DOT_BASE;
                r_ext    <= 3'd0;
            end else begin
                r_inside <= r_inside || !w_space;
                r_len    <= n_len;
                r_alive  <= n_alive;
                r_dollar <= n_dollar;
                r_quote  <= n_quote;
                r_base   <= n_base;
                r_dot    <= n_dot;
                r_ext    <= n_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_proc && w_emit) begin
            r_out_class <= w_class;
            r_out_len   <= n_len;
            r_out_last  <= r_in_last;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'd0, r_out_len, r_out_class};
    assign m_tlast  = r_out_last;

endmodule

// ===== hdl/cwc_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cwc_checker
// port-level checks on the classifier result stream
// ---------------------------------------------------------------------------
module cwc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result beat right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[3:0] <= 4'(cwc_pkg::CLS_EQUAL) && m_tdata[15:12] == 4'd0)
        else $error("token class out of range or pad bits set");

    a_length_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[11:4] != 8'd0)
        else $error("word of zero length");

    a_single_char_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tdata[3:0] == 4'(cwc_pkg::CLS_EQUAL) ||
                     m_tdata[3:0] == 4'(cwc_pkg::CLS_ROOT)) |-> m_tdata[11:4] == 8'd1)
        else $error("single-character class with wrong length");

endmodule

bind command_word_classifier_core cwc_checker u_cwc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== tb/command_word_classifier_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// command_word_classifier_core_tb
// streams command text into the classifier one character beat at a time and
// checks every word result (class, length, end of command) against an
// in-bench word matcher; both stream sides idle and stall at random
// ---------------------------------------------------------------------------
module command_word_classifier_core_tb;

    typedef struct {
        logic [7:0] code;
        logic       eoc;
        bit         pause;
    } t_char_beat;

    typedef struct {
        cwc_pkg::t_token_class cls;
        logic [7:0]            len;
        logic                  eoc;
    } t_word_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] char_code
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [3:0] token_class, [11:4] word_length
    logic        m_tlast;

    command_word_classifier_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // literal words in priority order, root last
    string                 lit_str [9] = '{"ls", "cd", "cat", "print", "exec", "set", "echo",
                                           "=", "\\"};
    cwc_pkg::t_token_class lit_cls [9] = '{cwc_pkg::CLS_LS, cwc_pkg::CLS_CD, cwc_pkg::CLS_CAT,
                                           cwc_pkg::CLS_PRINT, cwc_pkg::CLS_EXEC,
                                           cwc_pkg::CLS_SET, cwc_pkg::CLS_ECHO,
                                           cwc_pkg::CLS_EQUAL, cwc_pkg::CLS_ROOT};

    t_char_beat   pending_chars [$];
    t_word_result expected_words [$];
    logic [7:0]   word_buf [$];

    int queued_beats = 0;
    int beats_sent   = 0;
    int beats_taken  = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int tx_gap = 0, tx_quiet = 0;
    int rx_stall = 0, rx_quiet = 0, rx_last = 0;

    // word matcher state
    logic                  word_open;
    logic [7:0]            word_len;
    logic [8:0]            lit_alive;
    logic                  dollar_ok;
    cwc_pkg::t_quote_phase quote_st;
    logic [3:0]            base_len;
    cwc_pkg::t_dot_phase   dot_st;
    logic [2:0]            ext_len;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic bit is_ws(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic bit is_alnum(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10) return 8'(8'h30 + r);
        if (r < 36) return 8'(8'h41 + r - 10);
        return 8'(8'h61 + r - 36);
    endfunction

    function automatic logic [7:0] rand_other();
        logic [7:0] c;
        c = 8'($urandom);
        while (is_ws(c)) c = 8'($urandom);
        return c;
    endfunction

    function automatic logic [7:0] rand_ws();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'(8'h09 + r);
    endfunction

    task automatic clear_word();
        word_open = 1'b0;
        word_len  = 8'd0;
        lit_alive = '1;
        dollar_ok = 1'b0;
        quote_st  = cwc_pkg::QUOTE_DEAD;
        base_len  = 4'd0;
        dot_st    = cwc_pkg::DOT_BASE;
        ext_len   = 3'd0;
    endtask

    task automatic take_char(input logic [7:0] c);
        int  pos;
        int  i;
        bit  an;
        pos = word_len;
        an  = is_alnum(c);
        for (i = 0; i < 9; i++) begin
            if (pos >= lit_str[i].len()) lit_alive[i] = 1'b0;
            else if (lit_str[i][pos] != c) lit_alive[i] = 1'b0;
        end
        if (pos == 0) begin
            dollar_ok = (c == "$");
            quote_st  = (c == "\"") ? cwc_pkg::QUOTE_OPEN : cwc_pkg::QUOTE_DEAD;
        end else begin
            if (!an) dollar_ok = 1'b0;
            if (quote_st == cwc_pkg::QUOTE_OPEN) begin
                if (c == "\"") quote_st = cwc_pkg::QUOTE_CLOSED;
            end else begin
                quote_st = cwc_pkg::QUOTE_DEAD;
            end
        end
        if (dot_st == cwc_pkg::DOT_BASE) begin
            if (an) begin
                if (base_len < 4'd9) base_len++;
            end else if (c == "." && base_len >= 4'd1 && base_len <= 4'd8) begin
                dot_st = cwc_pkg::DOT_EXT;
            end else begin
                dot_st = cwc_pkg::DOT_DEAD;
            end
        end else if (dot_st == cwc_pkg::DOT_EXT) begin
            if (an) begin
                if (ext_len < 3'd4) ext_len++;
            end else begin
                dot_st = cwc_pkg::DOT_DEAD;
            end
        end
        if (word_len != 8'd255) word_len++;
        word_open = 1'b1;
    endtask

    function automatic cwc_pkg::t_token_class word_class();
        int i;
        for (i = 0; i < 8; i++) begin
            if (lit_alive[i] && word_len == lit_str[i].len()) return lit_cls[i];
        end
        if (dollar_ok && word_len >= 8'd2) return cwc_pkg::CLS_VARIABLE;
        if (quote_st == cwc_pkg::QUOTE_CLOSED) return cwc_pkg::CLS_QUOTED;
        if (dot_st == cwc_pkg::DOT_EXT && ext_len == 3'd3) return cwc_pkg::CLS_FILE;
        if (dot_st == cwc_pkg::DOT_BASE && base_len >= 4'd1 && base_len <= 4'd8) begin
            return cwc_pkg::CLS_FOLDER;
        end
        if (lit_alive[8] && word_len == lit_str[8].len()) return lit_cls[8];
        return cwc_pkg::CLS_UNKNOWN;
    endfunction

    task automatic predict_char(input logic [7:0] c, input logic eoc);
        bit           emit;
        t_word_result r;
        if (is_ws(c)) begin
            emit = word_open;
        end else begin
            take_char(c);
            emit = eoc;
        end
        if (emit) begin
            r.cls = word_class();
            r.len = word_len;
            r.eoc = eoc;
            expected_words.push_back(r);
        end
        if (emit || eoc) clear_word();
    endtask

    task automatic push_beat(input logic [7:0] c, input logic eoc);
        t_char_beat b;
        b.code  = c;
        b.eoc   = eoc;
        b.pause = 1'b0;
        pending_chars.push_back(b);
        queued_beats++;
    endtask

    task automatic push_pause();
        t_char_beat b;
        b.code  = 8'h00;
        b.eoc   = 1'b0;
        b.pause = 1'b1;
        pending_chars.push_back(b);
    endtask

    task automatic push_text(input string s, input logic eoc);
        int k;
        for (k = 0; k < s.len(); k++) push_beat(s[k], eoc && k == s.len() - 1);
    endtask

    task automatic push_alnums(input int n);
        int k;
        for (k = 0; k < n; k++) word_buf.push_back(rand_alnum());
    endtask

    task automatic make_word();
        int         n;
        int         k;
        string      s;
        logic [7:0] c;
        word_buf.delete();
        case ($urandom_range(0, 15))
            0, 1, 2: begin
                s = lit_str[$urandom_range(0, 6)];
                for (k = 0; k < s.len(); k++) word_buf.push_back(s[k]);
            end
            3: word_buf.push_back("=");
            4: word_buf.push_back("\\");
            5: begin
                word_buf.push_back("$");
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++) begin
                    word_buf.push_back(($urandom_range(0, 7) == 0) ? rand_other() : rand_alnum());
                end
            end
            6: begin
                word_buf.push_back("\"");
                n = $urandom_range(0, 6);
                for (k = 0; k < n; k++) begin
                    c = ($urandom_range(0, 1) == 0) ? rand_other() : rand_alnum();
                    word_buf.push_back((c == "\"") ? "q" : c);
                end
                case ($urandom_range(0, 5))
                    0: ;
                    1: begin
                        word_buf.push_back("\"");
                        word_buf.push_back(rand_other());
                    end
                    default: word_buf.push_back("\"");
                endcase
            end
            7: begin
                push_alnums($urandom_range(1, 8));
                word_buf.push_back(".");
                push_alnums(3);
            end
            8: begin
                push_alnums($urandom_range(0, 10));
                word_buf.push_back(".");
                push_alnums($urandom_range(0, 5));
                if ($urandom_range(0, 3) == 0) word_buf.push_back(rand_other());
            end
            9: push_alnums($urandom_range(1, 8));
            10: push_alnums($urandom_range(9, 12));
            11: begin
                s = lit_str[$urandom_range(0, 8)];
                case ($urandom_range(0, 2))
                    0: s = {s, "x"};
                    1: if (s.len() > 1) s = s.substr(0, s.len() - 2);
                    default: s[0] = rand_alnum();
                endcase
                for (k = 0; k < s.len(); k++) word_buf.push_back(s[k]);
            end
            12: begin
                case ($urandom_range(0, 4))
                    0: word_buf.push_back("$");
                    1: begin
                        word_buf.push_back("$");
                        word_buf.push_back(".");
                    end
                    2: begin
                        word_buf.push_back("\\");
                        word_buf.push_back("\\");
                    end
                    3: begin
                        word_buf.push_back("=");
                        word_buf.push_back("=");
                    end
                    default: word_buf.push_back("\"");
                endcase
            end
            15: begin
                if ($urandom_range(0, 3) == 0) begin
                    n = $urandom_range(250, 300);
                    case ($urandom_range(0, 2))
                        0: word_buf.push_back("$");
                        1: word_buf.push_back("\"");
                        default: word_buf.push_back(rand_alnum());
                    endcase
                    push_alnums(n - 2);
                    word_buf.push_back((word_buf[0] == "\"") ? "\"" : rand_alnum());
                end else begin
                    push_alnums($urandom_range(1, 3));
                    word_buf.push_back(rand_other());
                end
            end
            default: begin
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++) begin
                    word_buf.push_back(($urandom_range(0, 1) == 0) ? rand_other() : rand_alnum());
                end
            end
        endcase
    endtask

    task automatic add_command();
        int nw;
        int w;
        int k;
        int ns;
        bit end_on_char;
        if ($urandom_range(0, 3) == 0) begin
            ns = $urandom_range(1, 2);
            for (k = 0; k < ns; k++) push_beat(rand_ws(), 1'b0);
        end
        nw = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 5);
        end_on_char = (nw != 0) && ($urandom_range(0, 1) == 1);
        for (w = 0; w < nw; w++) begin
            make_word();
            for (k = 0; k < word_buf.size(); k++) begin
                push_beat(word_buf[k], end_on_char && w == nw - 1 && k == word_buf.size() - 1);
            end
            if (w < nw - 1) begin
                ns = $urandom_range(1, 3);
                for (k = 0; k < ns; k++) push_beat(rand_ws(), 1'b0);
            end
        end
        if (!end_on_char) begin
            ns = $urandom_range(1, 2);
            for (k = 0; k < ns; k++) push_beat(rand_ws(), k == ns - 1);
        end
    endtask

    // input side: one beat at a time with a random gap after each
    always @(negedge i_clk) begin
        logic       nv;
        logic [7:0] nd;
        logic       nl;
        t_char_beat head;
        if (i_rst_n && !(s_tvalid && beats_taken != beats_sent)) begin
            nv = 1'b0;
            nd = 8'($urandom);
            nl = 1'($urandom);
            if (s_tvalid) begin
                if (tx_quiet > 0) begin
                    tx_quiet--;
                    tx_gap = 0;
                end else begin
                    tx_gap = $urandom_range(0, 6);
                    if ($urandom_range(0, 7) == 0) tx_quiet = $urandom_range(20, 60);
                end
            end
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_chars.size() != 0 && pending_chars[0].pause) begin
                if (expected_words.size() == 0) void'(pending_chars.pop_front());
            end else if (pending_chars.size() != 0) begin
                head = pending_chars.pop_front();
                nv = 1'b1;
                nd = head.code;
                nl = head.eoc;
                beats_sent++;
            end
            s_tvalid <= nv;
            s_tdata  <= nd;
            s_tlast  <= nl;
        end
    end

    // output side: random stall before each result
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (results_seen != rx_last) begin
                rx_last = results_seen;
                if (rx_quiet > 0) begin
                    rx_quiet--;
                    rx_stall = 0;
                end else begin
                    rx_stall = $urandom_range(0, 6);
                    if ($urandom_range(0, 7) == 0) rx_quiet = $urandom_range(10, 40);
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result check first, then prediction for the beat taken at this edge
    always @(posedge i_clk) begin
        t_word_result want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_words.size() == 0) begin
                    $error("unexpected result: token_class %0d word_length %0d closes_command %0b",
                           m_tdata[3:0], m_tdata[11:4], m_tlast);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_tdata[3:0] !== want.cls) begin
                        $error("token_class: expected %0d, actual %0d", want.cls, m_tdata[3:0]);
                        mismatches++;
                    end
                    if (m_tdata[11:4] !== want.len) begin
                        $error("word_length: expected %0d, actual %0d", want.len, m_tdata[11:4]);
                        mismatches++;
                    end
                    if (m_tlast !== want.eoc) begin
                        $error("closes_command: expected %0b, actual %0b", want.eoc, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                beats_taken++;
                predict_char(s_tdata, s_tlast);
            end
        end
    end

    initial begin
        int next_pause;
        clear_word();

        // leading blank, equal, root closed by a final blank, variable closed by its
        // last character, zero and high bytes, lone final blank, blank kinds
        push_text(" ", 1'b0);
        push_text("=\t", 1'b0);
        push_text("\\ ", 1'b1);
        push_text("$a", 1'b1);
        push_beat(8'h00, 1'b0);
        push_beat(8'hff, 1'b1);
        push_text(" ", 1'b1);
        push_text("ls\n", 1'b0);
        push_text("cd\r", 1'b0);
        push_text("\"\"", 1'b0);
        push_beat(8'h0c, 1'b0);
        push_text("a.b", 1'b0);
        push_beat(8'h0b, 1'b1);
        push_pause();

        next_pause = queued_beats + 250;
        while (queued_beats < 1200) begin
            add_command();
            if (queued_beats >= next_pause) begin
                push_pause();
                next_pause += 250;
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || beats_taken != beats_sent ||
               expected_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
